// ===== sv/calendar_date_advance_core_assert.svh =====
// Assertion macros used by the checker file of the date advance core.
`ifndef CALENDAR_DATE_ADVANCE_CORE_ASSERT_SVH
`define CALENDAR_DATE_ADVANCE_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CDA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("date advance check failed");

// Consequent must hold in the cycle after the antecedent.
`define CDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("date advance check failed");

`endif

// ===== sv/cda_pkg.sv =====
package cda_pkg;

    // Width of the loan length register and of the day count field.
    localparam int unsigned LOAN_W = 10;

    // Default limit on the number of days added per transaction.
    localparam int unsigned MAX_DAYS_DEF = 1023;

    // Loan length after reset.
    localparam logic [LOAN_W-1:0] LOAN_RESET = 10'd28;

    // Month codes.
    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    // Year / 25 by reciprocal: floor(y * 83887 / 2^21) is exact for 16-bit y.
    localparam logic [16:0] DIV25_MUL   = 17'd83887;
    localparam int unsigned DIV25_SHIFT = 21;
    localparam int unsigned QUOT_W      = 12;
    localparam logic [4:0]  MOD25_LAST  = 5'd24;

    // Input transaction payload.
    typedef struct packed {
        logic [4:0]        start_day;
        logic [3:0]        start_month;
        logic [15:0]       start_year;
        logic [LOAN_W-1:0] day_count;
        logic              use_loan;
    } t_in_item;

    // Result transaction payload.
    typedef struct packed {
        logic [4:0]  result_day;
        logic [3:0]  result_month;
        logic [15:0] result_year;
        logic        result_leap;
    } t_out_item;

    // Configuration write payload.
    typedef logic [LOAN_W-1:0] t_loan_len;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_ready;
        logic div;
        logic modulo;
        logic norm;
        logic step;
        logic emit;
    } t_cda_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_valid;
        logic carry;
        logic out_free;
    } t_cda_stat;

    // Length of a month given its number and the leap flag of its year.
    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        unique case (month) inside
            MONTH_FEB:                                len = leap ? 5'd29 : 5'd28;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            default:                                  len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ===== sv/cda_chan_if.sv =====
// Valid/ready channel carrying one payload per transaction.
interface cda_chan_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/calendar_date_advance_core.sv =====
// Channel   Direction  Payload                                        Handshake
// i_cfg     in         loan days (10 bits)                            valid/ready
// i_in      in         start_day, start_month, start_year,            valid/ready
//                      day_count, use_loan
// o_out     out        result_day, result_month, result_year,         valid/ready
//                      result_leap
//
// After the input transaction is accepted, the sequencer divides, reduces and
// normalizes, then carries N month boundaries (at most 34 with 1023 days): one
// month is carried per cycle by the single subtract-and-compare in the datapath.
// The result register is loaded once it is free; the next input is taken after that.
// Reset is synchronous and active low; the loan length returns to 28.
// A new transaction is accepted only when the previous one has reached the
// result register; a stalled result holds there while the next one is taken.
// Configuration writes are always accepted.
module calendar_date_advance_core #(
    parameter int unsigned MAX_DAYS = cda_pkg::MAX_DAYS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cda_chan_if.sink    i_cfg,
    cda_chan_if.sink    i_in,
    cda_chan_if.source  o_out
);
    import cda_pkg::*;

    t_cda_cmd  w_cmd;
    t_cda_stat w_stat;

    // Sequencer.
    cda_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // Date arithmetic and result register.
    cda_datapath #(
        .MAX_DAYS (MAX_DAYS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .i_cfg   (i_cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

// ===== sv/cda_ctrl.sv =====
// Sequencer for one date advance: load, divide, reduce, normalize, carry, emit.
module cda_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cda_pkg::t_cda_stat i_stat,
    output cda_pkg::t_cda_cmd  o_cmd
);
    import cda_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV   = 6'b000010,
        S_MOD   = 6'b000100,
        S_NORM  = 6'b001000,
        S_CARRY = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.in_valid) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_state   = S_MOD;
            end
            S_MOD: begin
                o_cmd.modulo = 1'b1;
                n_state      = S_NORM;
            end
            S_NORM: begin
                o_cmd.norm = 1'b1;
                n_state    = S_CARRY;
            end
            S_CARRY: begin
                if (i_stat.carry) begin
                    o_cmd.step = 1'b1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== sv/cda_datapath.sv =====
// Date registers, leap tracking, month carry and the result register.
module cda_datapath #(
    parameter int unsigned MAX_DAYS = cda_pkg::MAX_DAYS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cda_pkg::t_cda_cmd  i_cmd,
    output cda_pkg::t_cda_stat o_stat,
    cda_chan_if.sink           i_cfg,
    cda_chan_if.sink           i_in,
    cda_chan_if.source         o_out
);
    import cda_pkg::*;

    localparam int unsigned DAY_W = $clog2(MAX_DAYS + 32);
    localparam int unsigned ADD_W = $clog2(MAX_DAYS + 1);

    t_loan_len         r_loan;
    logic [DAY_W-1:0]  r_day;
    logic [3:0]        r_month;
    logic [15:0]       r_year;
    logic [ADD_W-1:0]  r_add;
    logic [QUOT_W-1:0] r_quot;
    logic [4:0]        r_mod25;
    t_out_item         r_out;
    logic              r_out_valid;

    t_in_item          w_item;
    logic              w_load;
    logic [16:0]       w_raw_add;
    logic [16:0]       w_sat_add;
    logic [32:0]       w_prod;
    logic [15:0]       w_quot25;
    logic              w_leap;
    logic [4:0]        w_len;
    logic [DAY_W-1:0]  w_len_ext;
    logic [DAY_W-1:0]  w_norm_day;

    // Input side.
    assign w_item      = i_in.payload;
    assign w_load      = i_cmd.in_ready && i_in.valid;
    assign i_in.ready  = i_cmd.in_ready;
    assign i_cfg.ready = 1'b1;

    // Day count selection with saturation at the limit.
    assign w_raw_add = w_item.use_loan ? 17'(r_loan) : 17'(w_item.day_count);
    assign w_sat_add = (w_raw_add > 17'(MAX_DAYS)) ? 17'(MAX_DAYS) : w_raw_add;

    // Year divided by 25, then the remainder from the registered quotient.
    assign w_prod   = 33'(r_year) * 33'(DIV25_MUL);
    assign w_quot25 = 16'({r_quot, 4'b0000}) + 16'({r_quot, 3'b000}) + 16'(r_quot);

    // Gregorian rule: divisible by 4, and not by 100 unless by 400.
    assign w_leap = (r_year[1:0] == 2'b00) && ((r_mod25 != 5'd0) || (r_year[3:0] == 4'd0));

    // Length of the current month and the normalized starting day.
    assign w_len      = month_len(r_month, w_leap);
    assign w_len_ext  = DAY_W'(w_len);
    assign w_norm_day = ((r_day > w_len_ext) ? DAY_W'(1) : r_day) + DAY_W'(r_add);

    // Status to the controller.
    assign o_stat.in_valid = i_in.valid;
    assign o_stat.carry    = r_day > w_len_ext;
    assign o_stat.out_free = !r_out_valid || o_out.ready;

    // Loan length register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loan <= LOAN_RESET;
        end else if (i_cfg.valid) begin
            r_loan <= i_cfg.payload;
        end
    end

    // Working date registers.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_day  <= DAY_W'(w_item.start_day);
            r_year <= w_item.start_year;
            r_add  <= ADD_W'(w_sat_add);
            if (w_item.start_month == 4'd0 || w_item.start_month > MONTH_DEC) begin
                r_month <= MONTH_JAN;
            end else begin
                r_month <= w_item.start_month;
            end
        end
        if (i_cmd.div) begin
            r_quot <= w_prod[DIV25_SHIFT +: QUOT_W];
        end
        if (i_cmd.modulo) begin
            r_mod25 <= 5'(r_year - w_quot25);
        end
        if (i_cmd.norm) begin
            r_day <= w_norm_day;
        end
        // Carry one whole month; December rolls into the next year.
        if (i_cmd.step) begin
            r_day <= r_day - w_len_ext;
            if (r_month == MONTH_DEC) begin
                r_month <= MONTH_JAN;
                r_year  <= r_year + 16'd1;
                if (r_year == 16'hFFFF || r_mod25 == MOD25_LAST) begin
                    r_mod25 <= 5'd0;
                end else begin
                    r_mod25 <= r_mod25 + 5'd1;
                end
            end else begin
                r_month <= r_month + 4'd1;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.result_day   <= r_day[4:0];
            r_out.result_month <= r_month;
            r_out.result_year  <= r_year;
            r_out.result_leap  <= w_leap;
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

endmodule

// ===== sv/cda_checker.sv =====
`include "calendar_date_advance_core_assert.svh"

// Port-level checks of the date advance core.
module cda_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input cda_pkg::t_out_item i_out_payload
);
    import cda_pkg::*;

    logic w_in_fire;
    logic w_month_ok;
    logic w_leap_ok;
    logic w_out_stall;

    // Handshake and payload conditions used by the checks below.
    assign w_in_fire   = i_in_valid && i_in_ready;
    assign w_month_ok  = (i_out_payload.result_month >= MONTH_JAN)
                         && (i_out_payload.result_month <= MONTH_DEC);
    assign w_leap_ok   = !i_out_payload.result_leap
                         || (i_out_payload.result_year[1:0] == 2'b00);
    assign w_out_stall = i_out_valid && !i_out_ready;

    // One transaction at a time: the input closes right after an acceptance.
    `CDA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_in_fire, !i_in_ready)

    // Carried months always land in January through December.
    `CDA_ASSERT_NOW(a_month_range, i_clk, i_rst_n, i_out_valid, w_month_ok)

    // A leap result year is always a multiple of four.
    `CDA_ASSERT_NOW(a_leap_div4, i_clk, i_rst_n, i_out_valid, w_leap_ok)

    // A stalled result stays put.
    `CDA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall, i_out_valid && $stable(i_out_payload))

endmodule

bind calendar_date_advance_core cda_checker u_cda_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_payload (o_out.payload)
);
